// ----- hw/rtl/pet_coincidence_sorter_assert.svh -----
// Assertion macros for the coincidence sorter. Each check is clocked by i_clk
// and held off while i_rst_n is low.
`ifndef PET_COINCIDENCE_SORTER_ASSERT_SVH
`define PET_COINCIDENCE_SORTER_ASSERT_SVH
`ifndef SYNTHESIS
`define PCS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("coincidence sorter check failed");
`define PCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("coincidence sorter check failed");
`else
`define PCS_ASSERT_IMPLY(lbl, ante, cons)
`define PCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/pcs_pkg.sv -----
`default_nettype none
package pcs_pkg;

    localparam int STORE_DEPTH_DEF = 8;
    localparam int MAX_RESULTS     = 64;
    localparam int TIME_W          = 48;
    localparam int POS_W           = 20;

    localparam logic [2:0] CFG_WINDOW_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_WINDOW_OFFSET = 3'd1;
    localparam logic [2:0] CFG_POLICY        = 3'd2;
    localparam logic [2:0] CFG_MULTI_WINDOW  = 3'd3;
    localparam logic [2:0] CFG_MIN_TRANS     = 3'd4;
    localparam logic [2:0] CFG_MAX_AXIAL     = 3'd5;
    localparam logic [2:0] CFG_PLANE         = 3'd6;

    localparam logic [2:0] POL_ALL_GOODS     = 3'd1;
    localparam logic [2:0] POL_WINNER_GOODS  = 3'd2;
    localparam logic [2:0] POL_ONLY_ONE_GOOD = 3'd3;
    localparam logic [2:0] POL_WINNER_IF_GOOD = 3'd4;
    localparam logic [2:0] POL_WINNER_ALL_GOOD = 3'd5;

    localparam logic [1:0] PLANE_XY = 2'd0;
    localparam logic [1:0] PLANE_YZ = 2'd1;
    localparam logic [1:0] PLANE_XZ = 2'd2;

    localparam logic KIND_PAIR = 1'b0;
    localparam logic KIND_DROP = 1'b1;

    typedef struct packed {
        logic [47:0]        hit_time;
        logic [31:0]        group_id;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic [15:0]        energy;
        logic [31:0]        tag;
    } t_entry;

    typedef struct packed {
        logic        kind;
        logic [31:0] first_tag;
        logic [31:0] second_tag;
    } t_result;

    typedef struct packed {
        logic push;
        logic fin;
    } t_rq_ctrl;

    typedef enum logic [3:0] {
        S_IDLE, S_OPRD, S_SPAN, S_SRD, S_SEV, S_SGD, S_DEC,
        S_ESEL, S_TRD, S_TOUT, S_ADV, S_FIN
    } t_state;

endpackage
`default_nettype wire

// ----- hw/rtl/pcs_store.sv -----
`default_nettype none
module pcs_store import pcs_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_wr_en,
    input  wire [$clog2(STORE_DEPTH)-1:0] i_wr_addr,
    input  t_entry                        i_wr_data,
    input  wire                           i_rd_en,
    input  wire [$clog2(STORE_DEPTH)-1:0] i_rd_addr,
    output t_entry                        o_rd_data
);
    t_entry mem [STORE_DEPTH];
    t_entry r_rd_data;

    // Single write port, single registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

// ----- hw/rtl/pcs_geom.sv -----
`default_nettype none
module pcs_geom import pcs_pkg::*; (
    input  wire               i_clk,
    input  wire               i_en,
    input  wire signed [19:0] i_open_x,
    input  wire signed [19:0] i_open_y,
    input  wire signed [19:0] i_open_z,
    input  wire signed [19:0] i_cand_x,
    input  wire signed [19:0] i_cand_y,
    input  wire signed [19:0] i_cand_z,
    input  wire [1:0]         i_plane,
    input  wire [19:0]        i_max_axial,
    input  wire [19:0]        i_min_trans,
    output logic              o_good
);
    logic signed [20:0] dx, dy, dz, ax, t1, t2;
    logic [20:0] abs_ax;
    logic [40:0] n_sq1, n_sq2;
    logic [40:0] r_sq1, r_sq2;
    logic [20:0] r_abs_ax;
    logic        r_any;
    logic [39:0] r_min_sq;
    logic [41:0] sum;

    always_comb begin
        dx = 21'(i_open_x) - 21'(i_cand_x);
        dy = 21'(i_open_y) - 21'(i_cand_y);
        dz = 21'(i_open_z) - 21'(i_cand_z);
        case (i_plane)
            PLANE_XY: begin ax = dz; t1 = dx; t2 = dy; end
            PLANE_YZ: begin ax = dx; t1 = dy; t2 = dz; end
            PLANE_XZ: begin ax = dy; t1 = dx; t2 = dz; end
            default:  begin ax = dz; t1 = dx; t2 = dy; end
        endcase
        abs_ax = ax[20] ? 21'(-ax) : 21'(ax);
        n_sq1  = 41'(t1 * t1);
        n_sq2  = 41'(t2 * t2);
    end

    always_ff @(posedge i_clk) begin
        r_min_sq <= 40'(i_min_trans) * 40'(i_min_trans);
        if (i_en) begin
            r_sq1    <= n_sq1;
            r_sq2    <= n_sq2;
            r_abs_ax <= abs_ax;
            r_any    <= (i_plane != PLANE_XY) && (i_plane != PLANE_YZ)
                        && (i_plane != PLANE_XZ);
        end
    end

    assign sum = {1'b0, r_sq1} + {1'b0, r_sq2};
    assign o_good = r_any || ((r_abs_ax <= {1'b0, i_max_axial})
                    && (sum >= {2'b00, r_min_sq}));
endmodule
`default_nettype wire

// ----- hw/rtl/pcs_result_q.sv -----
`default_nettype none
module pcs_result_q import pcs_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_rq_ctrl i_ctrl,
    input  t_result  i_data,
    output logic     o_can_push,
    output logic     o_valid,
    input  wire      i_ready,
    output t_result  o_data,
    output logic     o_last
);
    // One result is held back until it is known whether another follows,
    // so that the last one of an item can carry the end mark.
    logic    r_pend_v, n_pend_v, r_out_v, n_out_v, r_out_last, n_out_last;
    t_result r_pend, n_pend, r_out, n_out;
    logic    free;

    assign free = !r_out_v || i_ready;
    assign o_can_push = !r_pend_v || free;

    always_comb begin
        n_pend_v = r_pend_v;
        n_pend = r_pend;
        n_out_v = r_out_v;
        n_out = r_out;
        n_out_last = r_out_last;
        if (r_out_v && i_ready) begin
            n_out_v = 1'b0;
        end
        if (i_ctrl.push) begin
            if (r_pend_v) begin
                n_out = r_pend;
                n_out_last = 1'b0;
                n_out_v = 1'b1;
            end
            n_pend = i_data;
            n_pend_v = 1'b1;
        end else if (i_ctrl.fin && r_pend_v) begin
            n_out = r_pend;
            n_out_last = 1'b1;
            n_out_v = 1'b1;
            n_pend_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_pend_v <= n_pend_v;
            r_out_v <= n_out_v;
        end
        r_pend <= n_pend;
        r_out <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_v;
    assign o_data = r_out;
    assign o_last = r_out_last;
endmodule
`default_nettype wire

// ----- hw/rtl/pet_coincidence_sorter.sv -----
// PET coincidence sorter. Time-ordered singles enter on the slave stream
// (tuser high means an end-of-run flush) and are kept in a store of
// STORE_DEPTH entries held in one synchronous memory. After each item the
// sequencer closes every window that is ready: it reads the opening single,
// checks the span up to the newest stored time, then scans the later entries
// one at a time, marking candidates and judging their geometry, applies the
// multiples policy and emits pairs on the master stream, tlast marking the
// last result of the item. Items are handled one at a time, and a single is
// stored as it is accepted. Each window test reads the opener and checks the
// span; a window that closes then reads and judges each later entry scanned,
// makes the policy decision, reads the partner of each emitted pair (under the
// all-goods policy stepping through the candidates) and advances the pointer.
// Each read goes through the single read port of the store. Every item ends
// with a step that marks the last result, which can stall on the output side.
// A full store drops the single with one result of kind 1.
// Configuration is accepted at any time but must only be changed while the
// block is idle.
`default_nettype none
`include "pet_coincidence_sorter_assert.svh"
module pet_coincidence_sorter import pcs_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // hit_time[47:0], group_id[79:48], pos_x[99:80], pos_y[119:100],
    // pos_z[139:120], energy[155:140], tag[187:156], zero fill above
    input  wire [191:0]  s_axis_tdata,
    // cmd
    input  wire          s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // first_tag[31:0], second_tag[63:32]
    output logic [63:0]  m_axis_tdata,
    // kind
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire [2:0]    i_cfg_index,
    input  wire [31:0]   i_cfg_data
);
    localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PW = $clog2(2 * STORE_DEPTH);
    localparam int PMOD = 2 * STORE_DEPTH;
    localparam int RCW = $clog2(MAX_RESULTS + 1);

    function automatic logic [IW-1:0] f_idx(input logic [PW-1:0] p);
        if ({1'b0, p} >= (PW+1)'(STORE_DEPTH)) begin
            return IW'({1'b0, p} - (PW+1)'(STORE_DEPTH));
        end
        return IW'(p);
    endfunction

    function automatic logic [PW-1:0] f_add(input logic [PW-1:0] p,
                                            input logic [PW:0] a);
        logic [PW+1:0] s;
        s = {2'b00, p} + {1'b0, a};
        if (s >= (PW+2)'(PMOD)) begin
            s = s - (PW+2)'(PMOD);
        end
        return PW'(s);
    endfunction

    // Configuration registers.
    logic [31:0] r_ww, r_wo;
    logic [2:0]  r_pol;
    logic        r_mw;
    logic [19:0] r_mint, r_maxa;
    logic [1:0]  r_plane;
    logic [32:0] r_hi;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ww <= 32'd10000;
            r_wo <= '0;
            r_pol <= '0;
            r_mw <= 1'b0;
            r_mint <= '0;
            r_maxa <= 20'hFFFFF;
            r_plane <= PLANE_XY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_WIDTH:  r_ww <= i_cfg_data;
                CFG_WINDOW_OFFSET: r_wo <= i_cfg_data;
                CFG_POLICY:        r_pol <= i_cfg_data[2:0];
                CFG_MULTI_WINDOW:  r_mw <= i_cfg_data[0];
                CFG_MIN_TRANS:     r_mint <= i_cfg_data[19:0];
                CFG_MAX_AXIAL:     r_maxa <= i_cfg_data[19:0];
                CFG_PLANE:         r_plane <= i_cfg_data[1:0];
                default: ;
            endcase
        end
        // Window end relative to the opener, refreshed every cycle.
        r_hi <= {1'b0, r_ww} + {1'b0, r_wo};
    end

    // Incoming single.
    t_entry in_entry;
    assign in_entry.hit_time = s_axis_tdata[47:0];
    assign in_entry.group_id = s_axis_tdata[79:48];
    assign in_entry.pos_x = s_axis_tdata[99:80];
    assign in_entry.pos_y = s_axis_tdata[119:100];
    assign in_entry.pos_z = s_axis_tdata[139:120];
    assign in_entry.energy = s_axis_tdata[155:140];
    assign in_entry.tag = s_axis_tdata[187:156];

    // Sequencer state.
    t_state r_state, n_state;
    logic [PW-1:0] r_wp, n_wp, r_op, n_op, r_p, n_p;
    logic r_flush, n_flush;
    logic [47:0] r_last_time, n_last_time;
    t_entry r_open, n_open;
    logic [IW-1:0] r_nc, n_nc, r_ngood, n_ngood, r_e, n_e;
    logic [IW-1:0] r_best_slot, n_best_slot, r_bg_slot, n_bg_slot;
    logic [IW-1:0] r_emit_slot, n_emit_slot, r_cslot;
    logic [15:0] r_best_en, n_best_en, r_bg_en, n_bg_en, r_cen;
    logic r_best_good, n_best_good, r_bg_found, n_bg_found, r_iter, n_iter;
    logic [RCW-1:0] r_cnt, n_cnt;
    logic signed [48:0] r_dt;
    logic r_gne;
    logic [IW-1:0] cand_slot [STORE_DEPTH];
    logic cand_good [STORE_DEPTH];
    logic cand_we;

    logic accept, full, wr_en, rd_en, geom_en, good;
    logic [IW-1:0] rd_addr;
    logic [PW:0] count;
    t_entry rd_data;
    t_rq_ctrl rq_ctrl;
    t_result rq_data, out_data;
    logic can_push;
    logic signed [49:0] span, lo50, hi50, dt50;
    logic is_cand;
    logic [PW-1:0] p_next;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign count = (r_wp >= r_op) ? {1'b0, r_wp} - {1'b0, r_op}
                                  : {1'b0, r_wp} + (PW+1)'(PMOD) - {1'b0, r_op};
    assign full = count >= (PW+1)'(STORE_DEPTH);
    assign wr_en = accept && !s_axis_tuser && !full;
    assign s_axis_tready = (r_state == S_IDLE);

    assign span = 50'($signed({2'b00, r_last_time})) - 50'($signed({2'b00, rd_data.hit_time}));
    assign lo50 = $signed({18'd0, r_wo});
    assign hi50 = $signed({17'd0, r_hi});
    assign dt50 = 50'(r_dt);
    assign is_cand = (dt50 >= lo50) && (dt50 <= hi50) && r_gne;
    assign p_next = f_add(r_p, (PW+1)'(1));

    pcs_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (f_idx(r_wp)),
        .i_wr_data (in_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pcs_geom u_geom (
        .i_clk       (i_clk),
        .i_en        (geom_en),
        .i_open_x    (r_open.pos_x),
        .i_open_y    (r_open.pos_y),
        .i_open_z    (r_open.pos_z),
        .i_cand_x    (rd_data.pos_x),
        .i_cand_y    (rd_data.pos_y),
        .i_cand_z    (rd_data.pos_z),
        .i_plane     (r_plane),
        .i_max_axial (r_maxa),
        .i_min_trans (r_mint),
        .o_good      (good)
    );

    pcs_result_q u_rq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (rq_ctrl),
        .i_data     (rq_data),
        .o_can_push (can_push),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (out_data),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {out_data.second_tag, out_data.first_tag};
    assign m_axis_tuser = out_data.kind;

    always_comb begin
        n_state = r_state;
        n_wp = r_wp;
        n_op = r_op;
        n_p = r_p;
        n_flush = r_flush;
        n_last_time = r_last_time;
        n_open = r_open;
        n_nc = r_nc;
        n_ngood = r_ngood;
        n_e = r_e;
        n_best_slot = r_best_slot;
        n_best_en = r_best_en;
        n_best_good = r_best_good;
        n_bg_slot = r_bg_slot;
        n_bg_en = r_bg_en;
        n_bg_found = r_bg_found;
        n_emit_slot = r_emit_slot;
        n_iter = r_iter;
        n_cnt = r_cnt;
        rd_en = 1'b0;
        rd_addr = f_idx(r_op);
        geom_en = 1'b0;
        cand_we = 1'b0;
        rq_ctrl = '0;
        rq_data.kind = KIND_PAIR;
        rq_data.first_tag = r_open.tag;
        rq_data.second_tag = rd_data.tag;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_flush = s_axis_tuser;
                    n_cnt = '0;
                    if (!s_axis_tuser && full) begin
                        // Store full: the single is dropped, nothing closes.
                        rq_ctrl.push = 1'b1;
                        rq_data.kind = KIND_DROP;
                        rq_data.first_tag = '0;
                        rq_data.second_tag = in_entry.tag;
                        n_cnt = RCW'(1);
                        n_state = S_FIN;
                    end else if (!s_axis_tuser) begin
                        n_wp = f_add(r_wp, (PW+1)'(1));
                        n_last_time = in_entry.hit_time;
                        n_state = S_OPRD;
                    end else if (r_op == r_wp) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_OPRD;
                    end
                end
            end
            S_OPRD: begin
                rd_en = 1'b1;
                rd_addr = f_idx(r_op);
                n_state = S_SPAN;
            end
            S_SPAN: begin
                n_open = rd_data;
                n_nc = '0;
                n_ngood = '0;
                n_bg_found = 1'b0;
                n_p = f_add(r_op, (PW+1)'(1));
                if (span > hi50 || (r_flush && span > lo50)) begin
                    n_state = (f_add(r_op, (PW+1)'(1)) == r_wp) ? S_DEC : S_SRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SRD: begin
                rd_en = 1'b1;
                rd_addr = f_idx(r_p);
                n_state = S_SEV;
            end
            S_SEV: begin
                geom_en = 1'b1;
                n_state = S_SGD;
            end
            S_SGD: begin
                if (is_cand) begin
                    cand_we = 1'b1;
                    n_nc = r_nc + IW'(1);
                    if (good) begin
                        n_ngood = r_ngood + IW'(1);
                    end
                    if (r_nc == '0 || r_cen > r_best_en) begin
                        n_best_slot = r_cslot;
                        n_best_en = r_cen;
                        n_best_good = good;
                    end
                    if (good && (!r_bg_found || r_cen > r_bg_en)) begin
                        n_bg_slot = r_cslot;
                        n_bg_en = r_cen;
                        n_bg_found = 1'b1;
                    end
                end
                // A single past the window end stops the scan.
                if (dt50 > hi50 || p_next == r_wp) begin
                    n_state = S_DEC;
                end else begin
                    n_p = p_next;
                    n_state = S_SRD;
                end
            end
            S_DEC: begin
                n_iter = 1'b0;
                n_e = '0;
                n_emit_slot = r_best_slot;
                n_state = S_ADV;
                if (r_nc == IW'(1)) begin
                    n_state = S_TRD;
                end else if (r_nc != '0) begin
                    case (r_pol)
                        POL_ALL_GOODS: begin
                            n_iter = 1'b1;
                            n_state = S_ESEL;
                        end
                        POL_ONLY_ONE_GOOD: begin
                            if (r_ngood == IW'(1)) begin
                                n_emit_slot = r_bg_slot;
                                n_state = S_TRD;
                            end
                        end
                        POL_WINNER_GOODS: begin
                            if (r_bg_found) begin
                                n_emit_slot = r_bg_slot;
                                n_state = S_TRD;
                            end
                        end
                        POL_WINNER_IF_GOOD: begin
                            if (r_best_good) begin
                                n_state = S_TRD;
                            end
                        end
                        POL_WINNER_ALL_GOOD: begin
                            if (r_ngood == r_nc) begin
                                n_state = S_TRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ESEL: begin
                if (r_e == r_nc) begin
                    n_state = S_ADV;
                end else begin
                    n_e = r_e + IW'(1);
                    if (cand_good[r_e]) begin
                        n_emit_slot = cand_slot[r_e];
                        n_state = S_TRD;
                    end
                end
            end
            S_TRD: begin
                rd_en = 1'b1;
                rd_addr = r_emit_slot;
                n_state = S_TOUT;
            end
            S_TOUT: begin
                if (can_push) begin
                    if (r_cnt < RCW'(MAX_RESULTS)) begin
                        rq_ctrl.push = 1'b1;
                        n_cnt = r_cnt + RCW'(1);
                    end
                    n_state = r_iter ? S_ESEL : S_ADV;
                end
            end
            S_ADV: begin
                if (r_mw) begin
                    n_op = f_add(r_op, (PW+1)'(1));
                end else begin
                    n_op = f_add(r_op, (PW+1)'(r_nc) + (PW+1)'(1));
                end
                n_state = (n_op == r_wp) ? S_FIN : S_OPRD;
            end
            S_FIN: begin
                if (can_push) begin
                    rq_ctrl.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp <= '0;
            r_op <= '0;
        end else begin
            r_state <= n_state;
            r_wp <= n_wp;
            r_op <= n_op;
        end
        r_p <= n_p;
        r_flush <= n_flush;
        r_last_time <= n_last_time;
        r_open <= n_open;
        r_nc <= n_nc;
        r_ngood <= n_ngood;
        r_e <= n_e;
        r_best_slot <= n_best_slot;
        r_best_en <= n_best_en;
        r_best_good <= n_best_good;
        r_bg_slot <= n_bg_slot;
        r_bg_en <= n_bg_en;
        r_bg_found <= n_bg_found;
        r_emit_slot <= n_emit_slot;
        r_iter <= n_iter;
        r_cnt <= n_cnt;
        if (geom_en) begin
            r_dt <= 49'($signed({1'b0, rd_data.hit_time})) -
                    49'($signed({1'b0, r_open.hit_time}));
            r_gne <= (rd_data.group_id != r_open.group_id);
            r_cen <= rd_data.energy;
            r_cslot <= f_idx(r_p);
        end
        if (cand_we) begin
            cand_slot[r_nc] <= r_cslot;
            cand_good[r_nc] <= good;
        end
    end

    `PCS_ASSERT_IMPLY(a_count_bound, 1'b1, count <= (PW+1)'(STORE_DEPTH))
    `PCS_ASSERT_NEXT(a_drop_ends, accept && !s_axis_tuser && full, r_state == S_FIN)
    `PCS_ASSERT_IMPLY(a_scan_in_store, r_state == S_SRD, r_p != r_wp)

endmodule
`default_nettype wire

// ----- tb/pet_coincidence_sorter_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pet_coincidence_sorter_tb;
    import pcs_pkg::*;

    localparam int DEPTH = STORE_DEPTH_DEF;
    localparam int PMOD = 2 * DEPTH;
    localparam longint CYCLE_LIMIT = 2000000;

    // One input item as the sender presents it.
    typedef struct {
        logic        cmd;
        logic [47:0] hit_time;
        logic [31:0] group_id;
        logic [19:0] px;
        logic [19:0] py;
        logic [19:0] pz;
        logic [15:0] energy;
        logic [31:0] tag;
    } t_single;

    typedef struct {
        logic        kind;
        logic [31:0] first_tag;
        logic [31:0] second_tag;
        logic        last;
    } t_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    pet_coincidence_sorter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Settings mirrored by the predictor.
    logic [31:0] win_width, win_offset;
    logic [2:0]  policy;
    logic        multi_win;
    logic [19:0] min_trans, max_axial;
    logic [1:0]  plane;

    // Window store copy.
    t_single     stored [DEPTH];
    int unsigned opener_ptr, write_ptr;
    logic [47:0] opener_time;
    bit          have_times;

    t_single single_queue[$];
    t_pair   pair_queue[$];
    int      errors = 0;
    int      idle_pct_in = 0, idle_pct_out = 0;
    bit      hold_off = 1'b0;
    longint  cycles = 0;
    int      pairs_seen = 0, drops_seen = 0;

    // Geometry test between the opener and one candidate.
    function automatic bit geometry_ok(t_single a, t_single b);
        longint dx, dy, dz, ax, t1, t2;
        dx = longint'($signed(a.px)) - longint'($signed(b.px));
        dy = longint'($signed(a.py)) - longint'($signed(b.py));
        dz = longint'($signed(a.pz)) - longint'($signed(b.pz));
        case (plane)
            PLANE_XY: begin ax = dz; t1 = dx; t2 = dy; end
            PLANE_YZ: begin ax = dx; t1 = dy; t2 = dz; end
            PLANE_XZ: begin ax = dy; t1 = dx; t2 = dz; end
            default: return 1'b1;
        endcase
        if (ax < 0) ax = -ax;
        if (ax > longint'(max_axial)) return 1'b0;
        return (t1 * t1 + t2 * t2) >= longint'(min_trans) * longint'(min_trans);
    endfunction

    function automatic void push_pair(logic kind, logic [31:0] a, logic [31:0] b,
                                      ref int n);
        t_pair p;
        if (n >= MAX_RESULTS) return;
        p.kind = kind; p.first_tag = a; p.second_tag = b; p.last = 1'b0;
        pair_queue = {pair_queue, p};
        n++;
    endfunction

    // Closes the window of the current opener, returns the candidate count.
    function automatic int close_window(ref int n);
        int cand [DEPTH];
        bit good [DEPTH];
        int nc, ngood, best, o, s, i;
        int unsigned p;
        longint lo, hi, dt;
        bit found;
        nc = 0; ngood = 0;
        o = opener_ptr % DEPTH;
        p = (opener_ptr + 1) % PMOD;
        lo = longint'(win_offset);
        hi = longint'(win_offset) + longint'(win_width);
        while (p != write_ptr && nc < DEPTH) begin
            s = p % DEPTH;
            dt = longint'(stored[s].hit_time) - longint'(stored[o].hit_time);
            if (dt >= lo && dt <= hi && stored[s].group_id != stored[o].group_id) begin
                cand[nc] = s;
                good[nc] = geometry_ok(stored[o], stored[s]);
                if (good[nc]) ngood++;
                nc++;
            end
            if (dt > hi) break;
            p = (p + 1) % PMOD;
        end
        if (nc == 0) return 0;
        if (nc == 1) begin
            push_pair(KIND_PAIR, stored[o].tag, stored[cand[0]].tag, n);
            return 1;
        end
        case (policy)
            POL_ALL_GOODS:
                for (i = 0; i < nc; i++)
                    if (good[i]) push_pair(KIND_PAIR, stored[o].tag, stored[cand[i]].tag, n);
            POL_WINNER_GOODS: begin
                found = 1'b0; best = 0;
                for (i = 0; i < nc; i++)
                    if (good[i] && (!found ||
                        stored[cand[i]].energy > stored[cand[best]].energy)) begin
                        best = i; found = 1'b1;
                    end
                if (found) push_pair(KIND_PAIR, stored[o].tag, stored[cand[best]].tag, n);
            end
            POL_ONLY_ONE_GOOD:
                if (ngood == 1)
                    for (i = 0; i < nc; i++)
                        if (good[i])
                            push_pair(KIND_PAIR, stored[o].tag, stored[cand[i]].tag, n);
            POL_WINNER_IF_GOOD, POL_WINNER_ALL_GOOD: begin
                best = 0;
                for (i = 1; i < nc; i++)
                    if (stored[cand[i]].energy > stored[cand[best]].energy) best = i;
                if (policy == POL_WINNER_IF_GOOD ? good[best] : (ngood == nc))
                    push_pair(KIND_PAIR, stored[o].tag, stored[cand[best]].tag, n);
            end
            default: ;
        endcase
        return nc;
    endfunction

    // Predicts the pairs caused by one accepted item.
    function automatic void predict_pairs(t_single it);
        int n, nc, base;
        int unsigned cnt, lastslot;
        longint span, full_w;
        n = 0;
        base = pair_queue.size();
        if (!it.cmd) begin
            cnt = (write_ptr + PMOD - opener_ptr) % PMOD;
            if (cnt >= DEPTH) begin
                push_pair(KIND_DROP, 32'd0, it.tag, n);
                pair_queue[base].last = 1'b1;
                return;
            end
            stored[write_ptr % DEPTH] = it;
            write_ptr = (write_ptr + 1) % PMOD;
            if (!have_times) begin
                opener_time = it.hit_time;
                have_times = 1'b1;
            end
        end
        full_w = longint'(win_width) + longint'(win_offset);
        while (have_times && opener_ptr != write_ptr) begin
            lastslot = ((write_ptr + PMOD - 1) % PMOD) % DEPTH;
            span = longint'(stored[lastslot].hit_time) - longint'(opener_time);
            if (!(span > full_w || (it.cmd && span > longint'(win_offset)))) break;
            nc = close_window(n);
            opener_ptr = (opener_ptr + (multi_win ? 1 : 1 + nc)) % PMOD;
            if (opener_ptr == write_ptr) begin
                have_times = 1'b0;
                break;
            end
            opener_time = stored[opener_ptr % DEPTH].hit_time;
        end
        if (opener_ptr == write_ptr) have_times = 1'b0;
        if (n > 0) pair_queue[base + n - 1].last = 1'b1;
    endfunction

    // Driver: presents queued items, with random gaps.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_pairs(single_queue.pop_front());
            end
            if ((!s_axis_tvalid || s_axis_tready) ) begin
                if (single_queue.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
                    !hold_off && $urandom_range(99) >= idle_pct_in &&
                    !(s_axis_tvalid && s_axis_tready && single_queue.size() == 0)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= single_queue[0].cmd;
                    s_axis_tdata  <= {4'd0, single_queue[0].tag, single_queue[0].energy,
                                      single_queue[0].pz, single_queue[0].py,
                                      single_queue[0].px, single_queue[0].group_id,
                                      single_queue[0].hit_time};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: accepts results with random stalls and checks them in order.
    always @(posedge i_clk) begin
        t_pair want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pair_queue.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result kind %0b tags %h", $time,
                             m_axis_tuser, m_axis_tdata);
                end else begin
                    want = pair_queue.pop_front();
                    if (m_axis_tuser) drops_seen++; else pairs_seen++;
                    if (m_axis_tuser !== want.kind) begin
                        errors++;
                        $display("%0t: kind expected %0b actual %0b", $time,
                                 want.kind, m_axis_tuser);
                    end
                    if (m_axis_tdata[31:0] !== want.first_tag) begin
                        errors++;
                        $display("%0t: first_tag expected %h actual %h", $time,
                                 want.first_tag, m_axis_tdata[31:0]);
                    end
                    if (m_axis_tdata[63:32] !== want.second_tag) begin
                        errors++;
                        $display("%0t: second_tag expected %h actual %h", $time,
                                 want.second_tag, m_axis_tdata[63:32]);
                    end
                    if (m_axis_tlast !== want.last) begin
                        errors++;
                        $display("%0t: last expected %0b actual %0b", $time,
                                 want.last, m_axis_tlast);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct_out);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_WINDOW_WIDTH:  win_width = val;
            CFG_WINDOW_OFFSET: win_offset = val;
            CFG_POLICY:        policy = val[2:0];
            CFG_MULTI_WINDOW:  multi_win = val[0];
            CFG_MIN_TRANS:     min_trans = val[19:0];
            CFG_MAX_AXIAL:     max_axial = val[19:0];
            CFG_PLANE:         plane = val[1:0];
            default: ;
        endcase
    endtask

    // Waits until every queued item is taken and every result has arrived.
    task automatic drain;
        while (single_queue.size() != 0 || s_axis_tvalid || pair_queue.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // A flush closes every window that can close, so the next phase starts
    // from a nearly empty store.
    task automatic flush_and_drain;
        t_single f;
        f = '{default: '0};
        f.cmd = 1'b1;
        single_queue = {single_queue, f};
        drain();
    endtask

    logic [47:0] now_time;

    function automatic t_single make_single(logic [47:0] t, logic [31:0] g);
        t_single s;
        s.cmd = 1'b0; s.hit_time = t; s.group_id = g;
        s.px = $urandom; s.py = $urandom; s.pz = $urandom;
        if ($urandom_range(3) == 0) begin
            s.px = $urandom_range(400) - 200;
            s.py = $urandom_range(400) - 200;
            s.pz = $urandom_range(400) - 200;
        end
        s.energy = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom);
        s.tag = $urandom;
        return s;
    endfunction

    // A burst of singles: mostly close in time from a few groups.
    task automatic queue_burst(int count);
        t_single s;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0: now_time = now_time + 48'($urandom_range(40000));
                1: now_time = now_time - 48'($urandom_range(300));
                default: now_time = now_time + 48'($urandom_range(4000));
            endcase
            s = make_single(now_time, $urandom_range(3));
            if ($urandom_range(15) == 0) s.group_id = $urandom;
            if ($urandom_range(20) == 0) s.cmd = 1'b1;
            single_queue = {single_queue, s};
        end
    endtask

    initial begin
        t_single s;
        win_width = 10000; win_offset = 0; policy = '0; multi_win = 0;
        min_trans = 0; max_axial = 20'hFFFFF; plane = PLANE_XY;
        opener_ptr = 0; write_ptr = 0; opener_time = '0; have_times = 0;
        now_time = 48'd1000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lone pair, extremes of fields, full store drop, flush.
        s = make_single(48'd0, 32'd0);
        s.px = 20'h80000; s.py = 20'h7FFFF; s.pz = 20'h80000;
        s.energy = 16'hFFFF; s.tag = 32'hFFFFFFFF;
        single_queue = {single_queue, s};
        s = make_single(48'd5000, 32'hFFFFFFFF);
        s.px = 20'h7FFFF; s.py = 20'h80000; s.pz = 20'h7FFFF; s.tag = 32'd0; s.energy = 0;
        single_queue = {single_queue, s};
        s = make_single(48'd5000, 32'd0);
        single_queue = {single_queue, s};
        for (int i = 0; i < 9; i++) begin
            s = make_single(48'd6000 + 48'(i), 32'(i % 3));
            single_queue = {single_queue, s};
        end
        flush_and_drain();

        // Every policy and plane in turn, with near-equal times and ties.
        for (int pol = 0; pol < 8; pol++) begin
            write_reg(CFG_POLICY, pol);
            write_reg(CFG_PLANE, pol % 4);
            write_reg(CFG_MIN_TRANS, (pol % 2) ? 150 : 0);
            write_reg(CFG_MAX_AXIAL, (pol % 3 == 0) ? 20'hFFFFF : 120);
            s = make_single(now_time, 32'd0);
            single_queue = {single_queue, s};
            for (int i = 0; i < 3; i++) begin
                s = make_single(now_time + 48'(100 * i), 32'd1 + i);
                s.energy = (i == 2) ? 16'd0 : 16'd500;
                single_queue = {single_queue, s};
            end
            now_time = now_time + 48'd100;
            flush_and_drain();
        end

        // Random phases across settings and idling patterns.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct_in = 0;  idle_pct_out = 0;  end
                1: begin idle_pct_in = 45; idle_pct_out = 0;  end
                2: begin idle_pct_in = 0;  idle_pct_out = 45; end
                default: begin idle_pct_in = 27; idle_pct_out = 27; end
            endcase
            case (ph)
                0: write_reg(CFG_WINDOW_WIDTH, 0);
                1: write_reg(CFG_WINDOW_WIDTH, 32'hFFFFFFFF);
                default: write_reg(CFG_WINDOW_WIDTH, $urandom_range(2000, 12000));
            endcase
            write_reg(CFG_WINDOW_OFFSET, (ph == 3) ? 32'hFFFFFFFF :
                                         (ph % 2) ? $urandom_range(1500) : 0);
            write_reg(CFG_POLICY, $urandom_range(7));
            write_reg(CFG_MULTI_WINDOW, ph % 2);
            write_reg(CFG_MIN_TRANS, (ph == 5) ? 20'hFFFFF : $urandom_range(300));
            write_reg(CFG_MAX_AXIAL, (ph == 6) ? 0 : $urandom_range(1048575));
            write_reg(CFG_PLANE, $urandom_range(3));
            queue_burst(7);
            if (ph == 2) begin
                // Sender holds off until everything expected so far has come.
                while (single_queue.size() != 0 || s_axis_tvalid) @(posedge i_clk);
                hold_off = 1'b1;
                while (pair_queue.size() != 0) @(posedge i_clk);
                hold_off = 1'b0;
            end
            queue_burst(7);
            flush_and_drain();
        end

        write_reg(CFG_WINDOW_WIDTH, 10000);
        write_reg(CFG_WINDOW_OFFSET, 0);
        // The largest time comes last, since nothing after it could close it.
        s = make_single(48'hFFFFFFFFFFFF, 32'd7);
        single_queue = {single_queue, s};
        flush_and_drain();
        drain();
        $display("Covered every policy and plane, drops, flushes and idle patterns:");
        $display("%0d pairs and %0d drop results checked.", pairs_seen, drops_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
